@@ hw/rtl/aro_pkg.sv @@
// Shared types and constants for the round-robin ADC oversampler.
package aro_pkg;

    localparam int CHANNELS_DEF          = 4;
    localparam int SAMPLES_PER_FRAME_DEF = 64;
    localparam int SAMPLE_BITS_DEF       = 10;

    localparam int SAMPLE_W  = 10;
    localparam int MUX_W     = 4;
    localparam int SUM_W     = 16;
    localparam int CHECK_W   = 8;
    localparam int MUX_REGS  = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [CHECK_W-1:0] CHECK_SEED = 8'hFF;

    typedef logic [MUX_W-1:0] mux_code_t;
    typedef mux_code_t [MUX_REGS-1:0] mux_bank_t;

    localparam mux_bank_t MUX_RESET = {4'hF, 4'h2, 4'h1, 4'h0};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MUX_FIRST  = 2'd0,
        REG_MUX_SECOND = 2'd1,
        REG_MUX_THIRD  = 2'd2,
        REG_MUX_FOURTH = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        mux_code_t          next_mux;
        logic               frame_done;
        logic [SUM_W-1:0]   sum_first;
        logic [SUM_W-1:0]   sum_second;
        logic [SUM_W-1:0]   sum_third;
        logic [SUM_W-1:0]   sum_fourth;
        logic [CHECK_W-1:0] frame_check;
    } result_t;

endpackage

@@ hw/rtl/aro_ifs.sv @@
// Valid/ready stream interfaces for conversion samples and frame results.
interface aro_sample_if;
    import aro_pkg::*;

    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

interface aro_result_if;
    import aro_pkg::*;

    logic               valid;
    logic               ready;
    mux_code_t          next_mux;
    logic               frame_done;
    logic [SUM_W-1:0]   sum_first;
    logic [SUM_W-1:0]   sum_second;
    logic [SUM_W-1:0]   sum_third;
    logic [SUM_W-1:0]   sum_fourth;
    logic [CHECK_W-1:0] frame_check;

    modport source (
        output valid, output next_mux, output frame_done, output sum_first,
        output sum_second, output sum_third, output sum_fourth, output frame_check,
        input ready
    );
    modport sink (
        input valid, input next_mux, input frame_done, input sum_first,
        input sum_second, input sum_third, input sum_fourth, input frame_check,
        output ready
    );
endinterface

@@ hw/rtl/adc_round_robin_oversampler.sv @@
// A sample is registered in the input stage, then its result in the result register.
// One sample per cycle while results flow; an input stage and a result register part
// the two sides, so one more sample is taken while a result waits downstream.
// Accumulate, publish and checksum fit one pass between the input stage and result.
// Reset clears all sums, counters and valid flags; mux codes return to 0, 1, 2, 15.
module adc_round_robin_oversampler #(
    parameter int CHANNELS          = aro_pkg::CHANNELS_DEF,
    parameter int SAMPLES_PER_FRAME = aro_pkg::SAMPLES_PER_FRAME_DEF,
    parameter int SAMPLE_BITS       = aro_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    aro_sample_if.sink                    samples,
    aro_result_if.source                  results,
    input  logic                          cfg_wr_en,
    input  logic [aro_pkg::CFG_IDX_W-1:0] cfg_index,
    input  aro_pkg::mux_code_t            cfg_data
);
    import aro_pkg::*;

    logic                a_valid_reg;
    logic                a_valid_next;
    logic [SAMPLE_W-1:0] a_sample_reg;
    logic [SAMPLE_W-1:0] a_sample_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    result_t             out_reg;
    result_t             out_next;

    mux_bank_t           mux_codes;
    result_t             calc;
    logic                a_adv;
    logic                in_beat;

    aro_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (cfg_wr_en),
        .index     (cfg_index),
        .data      (cfg_data),
        .mux_codes (mux_codes)
    );

    aro_accum #(
        .CHANNELS          (CHANNELS),
        .SAMPLES_PER_FRAME (SAMPLES_PER_FRAME),
        .SAMPLE_BITS       (SAMPLE_BITS)
    ) u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (a_adv),
        .sample    (a_sample_reg),
        .mux_codes (mux_codes),
        .result    (calc)
    );

    assign a_adv         = a_valid_reg && (!out_valid_reg || results.ready);
    assign samples.ready = !a_valid_reg || a_adv;
    assign in_beat       = samples.valid && samples.ready;

    always_comb
    begin
        a_valid_next   = in_beat ? 1'b1 : (a_adv ? 1'b0 : a_valid_reg);
        a_sample_next  = in_beat ? samples.sample : a_sample_reg;
        out_valid_next = a_adv ? 1'b1 : (results.ready ? 1'b0 : out_valid_reg);
        out_next       = a_adv ? calc : out_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg   <= a_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_sample_reg <= a_sample_next;
        out_reg      <= out_next;
    end

    assign results.valid       = out_valid_reg;
    assign results.next_mux    = out_reg.next_mux;
    assign results.frame_done  = out_reg.frame_done;
    assign results.sum_first   = out_reg.sum_first;
    assign results.sum_second  = out_reg.sum_second;
    assign results.sum_third   = out_reg.sum_third;
    assign results.sum_fourth  = out_reg.sum_fourth;
    assign results.frame_check = out_reg.frame_check;

    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg && out_valid_reg && !results.ready
            |=> a_valid_reg && $stable(a_sample_reg))
        else $error("input stage lost a sample under output stall");

endmodule

@@ hw/rtl/aro_cfg_regs.sv @@
// Mux code registers, one per channel slot, written through the config port.
module aro_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic [aro_pkg::CFG_IDX_W-1:0]  index,
    input  aro_pkg::mux_code_t             data,
    output aro_pkg::mux_bank_t             mux_codes
);
    import aro_pkg::*;

    mux_bank_t mux_reg;
    mux_bank_t mux_next;

    always_comb
    begin
        mux_next = mux_reg;
        if (wr_en)
        begin
            case (cfg_reg_t'(index))
                REG_MUX_FIRST:  mux_next[0] = data;
                REG_MUX_SECOND: mux_next[1] = data;
                REG_MUX_THIRD:  mux_next[2] = data;
                REG_MUX_FOURTH: mux_next[3] = data;
                default:        mux_next = mux_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mux_reg <= MUX_RESET;
        end
        else
        begin
            mux_reg <= mux_next;
        end
    end

    assign mux_codes = mux_reg;

endmodule

@@ hw/rtl/aro_accum.sv @@
// Per-slot accumulators, round counter, frame publish and checksum.
module aro_accum #(
    parameter int CHANNELS          = aro_pkg::CHANNELS_DEF,
    parameter int SAMPLES_PER_FRAME = aro_pkg::SAMPLES_PER_FRAME_DEF,
    parameter int SAMPLE_BITS       = aro_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic [aro_pkg::SAMPLE_W-1:0]  sample,
    input  aro_pkg::mux_bank_t            mux_codes,
    output aro_pkg::result_t              result
);
    import aro_pkg::*;

    localparam int SLOT_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int ROUND_W   = (SAMPLES_PER_FRAME > 1) ? $clog2(SAMPLES_PER_FRAME) : 1;
    localparam int KEEP_BITS = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'((1 << KEEP_BITS) - 1);
    localparam logic [SLOT_W-1:0]   LAST_SLOT   = SLOT_W'(CHANNELS - 1);
    localparam logic [ROUND_W-1:0]  LAST_ROUND  = ROUND_W'(SAMPLES_PER_FRAME - 1);

    logic [SLOT_W-1:0]  slot_reg;
    logic [SLOT_W-1:0]  slot_next;
    logic [ROUND_W-1:0] round_reg;
    logic [ROUND_W-1:0] round_next;
    logic [SUM_W-1:0]   run_reg   [CHANNELS];
    logic [SUM_W-1:0]   run_next  [CHANNELS];
    logic [SUM_W-1:0]   pub_reg   [CHANNELS];
    logic [SUM_W-1:0]   pub_next  [CHANNELS];
    logic [CHECK_W-1:0] check_reg;
    logic [CHECK_W-1:0] check_next;

    logic [SUM_W-1:0]   upd       [CHANNELS];
    logic [SUM_W-1:0]   sample_ext;
    logic [CHECK_W-1:0] frame_sum;
    logic               wrap_slot;
    logic               publish;
    logic [2:0]         slot_wide;
    logic [SUM_W-1:0]   pub_view  [4];

    assign sample_ext = SUM_W'(sample & SAMPLE_MASK);
    assign wrap_slot  = (slot_reg == LAST_SLOT);
    assign publish    = wrap_slot && (round_reg == LAST_ROUND);

    always_comb
    begin
        frame_sum = CHECK_SEED;
        for (int s = 0; s < CHANNELS; s++)
        begin
            upd[s] = (slot_reg == SLOT_W'(s)) ? run_reg[s] + sample_ext : run_reg[s];
            frame_sum = frame_sum + upd[s][7:0] + upd[s][15:8];
        end
    end

    always_comb
    begin
        slot_next  = slot_reg;
        round_next = round_reg;
        check_next = check_reg;
        for (int s = 0; s < CHANNELS; s++)
        begin
            run_next[s] = run_reg[s];
            pub_next[s] = pub_reg[s];
        end
        if (step)
        begin
            slot_next = wrap_slot ? '0 : slot_reg + 1'b1;
            if (wrap_slot)
            begin
                round_next = publish ? '0 : round_reg + 1'b1;
            end
            for (int s = 0; s < CHANNELS; s++)
            begin
                run_next[s] = publish ? '0 : upd[s];
                pub_next[s] = publish ? upd[s] : pub_reg[s];
            end
            if (publish)
            begin
                check_next = frame_sum;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg  <= '0;
            round_reg <= '0;
            check_reg <= '0;
            for (int s = 0; s < CHANNELS; s++)
            begin
                run_reg[s] <= '0;
                pub_reg[s] <= '0;
            end
        end
        else
        begin
            slot_reg  <= slot_next;
            round_reg <= round_next;
            check_reg <= check_next;
            for (int s = 0; s < CHANNELS; s++)
            begin
                run_reg[s] <= run_next[s];
                pub_reg[s] <= pub_next[s];
            end
        end
    end

    // Slots past the fourth reuse the mux code of slot modulo 4.
    assign slot_wide = 3'(slot_next);

    for (genvar k = 0; k < 4; k++)
    begin : g_view
        if (k < CHANNELS)
        begin : g_live
            assign pub_view[k] = pub_next[k];
        end
        else
        begin : g_absent
            assign pub_view[k] = '0;
        end
    end

    always_comb
    begin
        result.next_mux    = mux_codes[slot_wide[1:0]];
        result.frame_done  = publish;
        result.sum_first   = pub_view[0];
        result.sum_second  = pub_view[1];
        result.sum_third   = pub_view[2];
        result.sum_fourth  = pub_view[3];
        result.frame_check = check_next;
    end

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg <= LAST_SLOT)
        else $error("slot index past last channel");

    a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
        round_reg <= LAST_ROUND)
        else $error("round count past frame length");

    a_clear_on_publish: assert property (@(posedge clk) disable iff (!rst_n)
        step && publish |=> run_reg[0] == '0 && slot_reg == '0 && round_reg == '0)
        else $error("running sums not cleared after publish");

    a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(slot_reg) && $stable(round_reg) && $stable(check_reg))
        else $error("accumulator state moved without a sample");

endmodule

@@ tb/tb_adc_round_robin_oversampler.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the round-robin ADC oversampler.
module tb_adc_round_robin_oversampler;
    import aro_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_ITEMS  = 1400;
    localparam int SETTLE_CYCLES = 8;

    typedef enum int {
        STYLE_UNIFORM,
        STYLE_FULL_SCALE,
        STYLE_ZERO,
        STYLE_NEAR_MAX,
        STYLE_ONE_BIT
    } frame_style_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    mux_code_t          cfg_data;

    aro_sample_if sample_ch ();
    aro_result_if result_ch ();

    adc_round_robin_oversampler u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (sample_ch),
        .results   (result_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predicted state of the oversampler
    mux_bank_t          mux_bank_model;
    logic [1:0]         slot_now;
    logic [5:0]         round_now;
    logic [SUM_W-1:0]   running_sum [MUX_REGS];
    logic [SUM_W-1:0]   frame_sum [MUX_REGS];
    logic [CHECK_W-1:0] frame_check_now;

    result_t expected_results [$];

    bit tx_idle = 1'b1;
    bit rx_idle = 1'b1;
    int errors;
    int samples_sent;
    int results_checked;
    int frames_published;
    int bank_reloads;
    int cycles;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic clear_model();
        mux_bank_model  = MUX_RESET;
        slot_now        = '0;
        round_now       = '0;
        frame_check_now = '0;
        for (int k = 0; k < MUX_REGS; k++)
        begin
            running_sum[k] = '0;
            frame_sum[k]   = '0;
        end
    endtask

    // Adds one sample to the current slot and returns the result it produces.
    function automatic result_t accumulate_sample(logic [SAMPLE_W-1:0] value);
        result_t            res;
        logic [CHECK_W-1:0] chk;
        res = '0;
        running_sum[slot_now] = running_sum[slot_now] + SUM_W'(value);
        if (slot_now == 2'(CHANNELS_DEF - 1))
        begin
            slot_now = '0;
            if (round_now == 6'(SAMPLES_PER_FRAME_DEF - 1))
            begin
                round_now = '0;
                chk = CHECK_SEED;
                for (int k = 0; k < MUX_REGS; k++)
                begin
                    frame_sum[k]   = running_sum[k];
                    chk            = chk + running_sum[k][7:0] + running_sum[k][15:8];
                    running_sum[k] = '0;
                end
                frame_check_now = chk;
                res.frame_done  = 1'b1;
            end
            else
            begin
                round_now = round_now + 1'b1;
            end
        end
        else
        begin
            slot_now = slot_now + 1'b1;
        end
        res.next_mux    = mux_bank_model[slot_now];
        res.sum_first   = frame_sum[0];
        res.sum_second  = frame_sum[1];
        res.sum_third   = frame_sum[2];
        res.sum_fourth  = frame_sum[3];
        res.frame_check = frame_check_now;
        return res;
    endfunction

    task automatic send_sample(input logic [SAMPLE_W-1:0] value);
        int gap;
        gap = tx_idle ? $urandom_range(0, 15) : 0;
        repeat (gap)
        begin
            @(negedge clk);
            sample_ch.valid  <= 1'b0;
            sample_ch.sample <= SAMPLE_W'($urandom);
        end
        @(negedge clk);
        sample_ch.valid  <= 1'b1;
        sample_ch.sample <= value;
        do
            @(posedge clk);
        while (!sample_ch.ready);
        expected_results.push_back(accumulate_sample(value));
        samples_sent++;
    endtask

    // Sender goes quiet until every predicted result has been seen.
    task automatic drain_results();
        @(negedge clk);
        sample_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_mux_bank(input mux_bank_t bank);
        cfg_reg_t reg_sel;
        reg_sel = reg_sel.first();
        do
        begin
            @(negedge clk);
            cfg_wr_en <= 1'b1;
            cfg_index <= reg_sel;
            cfg_data  <= bank[reg_sel];
            @(posedge clk);
            mux_bank_model[reg_sel] = bank[reg_sel];
            reg_sel = reg_sel.next();
        end
        while (reg_sel != reg_sel.first());
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        bank_reloads++;
    endtask

    task automatic compare_field(input string name, input logic [SUM_W-1:0] want,
                                 input logic [SUM_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    initial
    begin : result_checker
        int      stall;
        result_t got;
        result_t want;
        result_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = rx_idle ? $urandom_range(0, 15) : 0;
            repeat (stall)
            begin
                @(negedge clk);
                result_ch.ready <= 1'b0;
            end
            @(negedge clk);
            result_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!result_ch.valid);
            got.next_mux    = result_ch.next_mux;
            got.frame_done  = result_ch.frame_done;
            got.sum_first   = result_ch.sum_first;
            got.sum_second  = result_ch.sum_second;
            got.sum_third   = result_ch.sum_third;
            got.sum_fourth  = result_ch.sum_fourth;
            got.frame_check = result_ch.frame_check;
            if (expected_results.size() == 0)
            begin
                $error("result beat with no sample pending");
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                compare_field("next_mux", SUM_W'(want.next_mux), SUM_W'(got.next_mux));
                compare_field("frame_done", SUM_W'(want.frame_done),
                              SUM_W'(got.frame_done));
                compare_field("sum_first", want.sum_first, got.sum_first);
                compare_field("sum_second", want.sum_second, got.sum_second);
                compare_field("sum_third", want.sum_third, got.sum_third);
                compare_field("sum_fourth", want.sum_fourth, got.sum_fourth);
                compare_field("frame_check", SUM_W'(want.frame_check),
                              SUM_W'(got.frame_check));
                if (want.frame_done)
                    frames_published++;
                results_checked++;
            end
        end
    end

    // Default mux codes, zero checksum before the first frame.
    task automatic test_reset_defaults();
        send_sample('0);
        send_sample('1);
        send_sample('0);
        send_sample('1);
        drain_results();
    endtask

    task automatic test_sample_extremes();
        for (int b = 0; b < SAMPLE_W; b++)
            send_sample(SAMPLE_W'(1) << b);
        send_sample(10'h155);
        send_sample(10'h2AA);
        send_sample('0);
        send_sample('1);
        drain_results();
    endtask

    task automatic test_mux_codes();
        set_mux_bank('1);
        send_sample(SAMPLE_W'($urandom));
        send_sample(SAMPLE_W'($urandom));
        drain_results();
        set_mux_bank('0);
        send_sample(SAMPLE_W'($urandom));
        send_sample(SAMPLE_W'($urandom));
        drain_results();
        set_mux_bank({4'hC, 4'h3, 4'hA, 4'h5});
        send_sample(SAMPLE_W'($urandom));
        send_sample(SAMPLE_W'($urandom));
        drain_results();
    endtask

    // Long run of random samples; each frame takes one value profile.
    task automatic test_random_frames();
        int                  phase_left;
        frame_style_t        style;
        logic [SAMPLE_W-1:0] value;
        phase_left = 0;
        style      = STYLE_UNIFORM;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (phase_left == 0)
            begin
                drain_results();
                case ($urandom_range(0, 5))
                    0:       set_mux_bank('0);
                    1:       set_mux_bank('1);
                    2:       set_mux_bank(MUX_RESET);
                    default: set_mux_bank(mux_bank_t'($urandom));
                endcase
                {tx_idle, rx_idle} = 2'($urandom_range(0, 3));
                phase_left = $urandom_range(60, 250);
            end
            phase_left--;
            if (slot_now == '0 && round_now == '0)
            begin
                case ($urandom_range(0, 7))
                    0:       style = STYLE_FULL_SCALE;
                    1:       style = STYLE_ZERO;
                    2:       style = STYLE_NEAR_MAX;
                    3:       style = STYLE_ONE_BIT;
                    default: style = STYLE_UNIFORM;
                endcase
            end
            case (style)
                STYLE_FULL_SCALE: value = '1;
                STYLE_ZERO:       value = '0;
                STYLE_NEAR_MAX:   value = SAMPLE_W'($urandom_range(990, 1023));
                STYLE_ONE_BIT:    value = SAMPLE_W'(1) << $urandom_range(0, SAMPLE_W - 1);
                default:          value = SAMPLE_W'($urandom);
            endcase
            send_sample(value);
        end
        drain_results();
    endtask

    initial
    begin : stimulus
        rst_n            = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_index        = REG_MUX_FIRST;
        cfg_data         = '0;
        sample_ch.valid  = 1'b0;
        sample_ch.sample = '0;
        clear_model();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_sample_extremes();
        test_mux_codes();
        test_random_frames();

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Run: %0d samples sent, %0d result beats checked, %0d frames published.",
                 samples_sent, results_checked, frames_published);
        $display("Mux bank reloaded %0d times, with idle and stall patterns on both sides.",
                 bank_reloads);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

@@ adc_round_robin_oversampler.f @@
hw/rtl/aro_pkg.sv
hw/rtl/aro_ifs.sv
hw/rtl/aro_cfg_regs.sv
hw/rtl/aro_accum.sv
hw/rtl/adc_round_robin_oversampler.sv
tb/tb_adc_round_robin_oversampler.sv
